// ----- hw/rtl/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; used by the channel interfaces and all RTL modules.
package rc4_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned PERM_DEPTH      = 256;
  localparam int unsigned PERM_AW         = $clog2(PERM_DEPTH);
  localparam int unsigned KEY_MAX_LEN_DEF = 256;

  localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

  // Function codes of an input transaction
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TXT_J,
    ST_TXT_T,
    ST_TXT_OUT,
    ST_KS_RD,
    ST_KS_SW,
    ST_KS_FIN
  } state_t;

  // One cycle's worth of accesses to the permutation store
  typedef struct packed {
    logic                clear;
    logic                re;
    logic [PERM_AW-1:0]  raddr;
    logic                we;
    logic [PERM_AW-1:0]  waddr;
    logic [BYTE_W-1:0]   wdata;
  } perm_cmd_t;

endpackage

// ----- hw/rtl/rc4_ifs.sv -----
// Valid/ready channel interfaces for the RC4 block: input and result.
// Depends on rc4_pkg for the byte width.
interface rc4_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [rc4_pkg::BYTE_W-1:0]  in_byte;
  logic                        key_last;

  modport source (output valid, func, in_byte, key_last, input ready);
  modport sink   (input valid, func, in_byte, key_last, output ready);
endinterface

interface rc4_out_if;
  logic                        valid;
  logic                        ready;
  logic [rc4_pkg::BYTE_W-1:0]  out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

// ----- hw/rtl/rc4_stream_cipher.sv -----
// RC4 stream cipher. Text byte: the result is loaded into the output register in
// ST_TXT_OUT after ST_TXT_J and ST_TXT_T; the next text byte is taken only then, set by
// the three dependent reads of the one-read-port permutation RAM. The last key byte
// starts the key schedule, ST_KS_RD then ST_KS_SW per swap step, with no input accepted.
// Reset (synchronous, active low) clears control, indices and key count; the
// permutation reads as identity at once through valid bits, no clearing pass.
module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX_LEN = rc4_pkg::KEY_MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rc4_in_if.sink            in_ch,
  rc4_out_if.source         out_ch
);

  localparam int unsigned KEY_AW = (KEY_MAX_LEN > 1) ? $clog2(KEY_MAX_LEN) : 1;
  localparam int unsigned KCW    = $clog2(KEY_MAX_LEN + 1);
  localparam int unsigned BW     = rc4_pkg::BYTE_W;
  localparam int unsigned AW     = rc4_pkg::PERM_AW;

  rc4_pkg::state_t     state_r, state_nxt;
  rc4_pkg::perm_cmd_t  perm_cmd;
  logic [BW-1:0]       perm_rdata;

  // Keystream indices; j also accumulates during the key schedule
  logic [AW-1:0]       i_r, i_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  // Schedule step counter and key index (n mod key length)
  logic [AW-1:0]       n_r, n_nxt;
  logic [KEY_AW-1:0]   kidx_r, kidx_nxt;
  logic [KCW-1:0]      key_len_r, key_len_nxt;
  logic [KCW-1:0]      key_count_r, key_count_nxt;

  // Per-transaction working values
  logic [BW-1:0]       byte_r, byte_nxt;
  logic [BW-1:0]       si_r, si_nxt;
  logic [BW-1:0]       sj_r, sj_nxt;
  logic                fwd_r, fwd_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BW-1:0]       out_byte_r, out_byte_nxt;
  logic                out_load;
  logic                out_free;

  logic                in_ready;
  logic                in_accept;
  logic                key_room;

  // Key store
  logic [BW-1:0]       key_mem [KEY_MAX_LEN];
  logic                key_we;
  logic [KEY_AW-1:0]   key_waddr;
  logic [BW-1:0]       key_rd_r;

  logic [AW-1:0]       j_txt;
  logic [AW-1:0]       t_idx;
  logic [AW-1:0]       j_ks;
  logic [KEY_AW-1:0]   kidx_inc;

  rc4_perm_store u_perm (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (perm_cmd),
    .rdata (perm_rdata)
  );

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

  assign in_accept = in_ch.valid && in_ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign key_room  = key_count_r < KCW'(KEY_MAX_LEN);

  // Index arithmetic wraps mod 256 by width
  assign j_txt    = j_r + AW'(perm_rdata);
  assign t_idx    = AW'(si_r + perm_rdata);
  assign j_ks     = j_r + AW'(perm_rdata) + AW'(key_rd_r);
  assign kidx_inc = ((KCW'(kidx_r) + KCW'(1)) == key_len_r) ? '0 : kidx_r + KEY_AW'(1);

  // Key store: written by key transactions, read during the schedule
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= in_ch.in_byte;
    end
    key_rd_r <= key_mem[kidx_r];
  end

  assign key_waddr = key_count_r[KEY_AW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc4_pkg::ST_IDLE,
      rc4_pkg::ST_TXT_OUT: begin
        // Hold in the result state until the output register frees up
        if (state_r == rc4_pkg::ST_TXT_OUT && !out_free) begin
          state_nxt = rc4_pkg::ST_TXT_OUT;
        end else if (in_accept && in_ch.func == rc4_pkg::FUNC_TEXT) begin
          state_nxt = rc4_pkg::ST_TXT_J;
        end else if (in_accept && in_ch.key_last) begin
          state_nxt = rc4_pkg::ST_KS_RD;
        end else begin
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_TXT_J:  state_nxt = rc4_pkg::ST_TXT_T;
      rc4_pkg::ST_TXT_T:  state_nxt = rc4_pkg::ST_TXT_OUT;
      rc4_pkg::ST_KS_RD:  state_nxt = rc4_pkg::ST_KS_SW;
      rc4_pkg::ST_KS_SW: begin
        state_nxt = (n_r == rc4_pkg::PERM_LAST) ? rc4_pkg::ST_KS_FIN : rc4_pkg::ST_KS_RD;
      end
      rc4_pkg::ST_KS_FIN: state_nxt = rc4_pkg::ST_IDLE;
      default:            state_nxt = rc4_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory accesses
  always_comb begin
    perm_cmd      = '0;
    key_we        = 1'b0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    kidx_nxt      = kidx_r;
    key_len_nxt   = key_len_r;
    key_count_nxt = key_count_r;
    byte_nxt      = byte_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    fwd_nxt       = fwd_r;
    out_byte_nxt  = out_byte_r;

    case (state_r)
      rc4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      rc4_pkg::ST_TXT_J: begin
        // S[i] arrived: advance j, read S[j], store S[i] at j
        si_nxt         = perm_rdata;
        j_nxt          = j_txt;
        perm_cmd.re    = 1'b1;
        perm_cmd.raddr = j_txt;
        perm_cmd.we    = 1'b1;
        perm_cmd.waddr = j_txt;
        perm_cmd.wdata = perm_rdata;
      end
      rc4_pkg::ST_TXT_T: begin
        // Old S[j] arrived: finish the swap, read S[S[i]+S[j]]
        sj_nxt         = perm_rdata;
        perm_cmd.we    = 1'b1;
        perm_cmd.waddr = i_r;
        perm_cmd.wdata = perm_rdata;
        perm_cmd.re    = 1'b1;
        perm_cmd.raddr = t_idx;
        // The read misses this cycle's write to entry i: forward it
        fwd_nxt        = (t_idx == i_r);
      end
      rc4_pkg::ST_TXT_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_byte_nxt = byte_r ^ (fwd_r ? sj_r : perm_rdata);
          in_ready     = 1'b1;
        end
      end
      rc4_pkg::ST_KS_RD: begin
        // Read S[n] and key byte; complete the previous step's swap
        perm_cmd.re    = 1'b1;
        perm_cmd.raddr = n_r;
        if (n_r != '0) begin
          perm_cmd.we    = 1'b1;
          perm_cmd.waddr = n_r - AW'(1);
          perm_cmd.wdata = perm_rdata;
        end
        kidx_nxt = kidx_inc;
      end
      rc4_pkg::ST_KS_SW: begin
        j_nxt          = j_ks;
        perm_cmd.re    = 1'b1;
        perm_cmd.raddr = j_ks;
        perm_cmd.we    = 1'b1;
        perm_cmd.waddr = j_ks;
        perm_cmd.wdata = perm_rdata;
        if (n_r != rc4_pkg::PERM_LAST) begin
          n_nxt = n_r + AW'(1);
        end
      end
      rc4_pkg::ST_KS_FIN: begin
        perm_cmd.we    = 1'b1;
        perm_cmd.waddr = n_r;
        perm_cmd.wdata = perm_rdata;
        i_nxt          = '0;
        j_nxt          = '0;
      end
      default: ;
    endcase

    if (in_accept) begin
      if (in_ch.func == rc4_pkg::FUNC_TEXT) begin
        // Advance i and fetch S[i]
        i_nxt          = i_r + AW'(1);
        byte_nxt       = in_ch.in_byte;
        perm_cmd.re    = 1'b1;
        perm_cmd.raddr = i_r + AW'(1);
      end else begin
        // Drop key bytes once the store is full
        if (key_room) begin
          key_we        = 1'b1;
          key_count_nxt = key_count_r + KCW'(1);
        end
        if (in_ch.key_last) begin
          key_len_nxt    = key_room ? key_count_r + KCW'(1) : key_count_r;
          key_count_nxt  = '0;
          perm_cmd.clear = 1'b1;
          j_nxt          = '0;
          n_nxt          = '0;
          kidx_nxt       = '0;
        end
      end
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_count_r <= key_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    kidx_r     <= kidx_nxt;
    key_len_r  <= key_len_nxt;
    byte_r     <= byte_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    fwd_r      <= fwd_nxt;
    out_byte_r <= out_byte_nxt;
  end

endmodule

// ----- hw/rtl/rc4_perm_store.sv -----
// 256-entry permutation store: synchronous RAM, one read and one write a cycle.
// Per-entry valid bits make unwritten entries read as the identity value.
// Depends on rc4_pkg.
module rc4_perm_store (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rc4_pkg::perm_cmd_t                   cmd,
  output logic [rc4_pkg::BYTE_W-1:0]           rdata
);

  logic [rc4_pkg::BYTE_W-1:0]  perm_mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0] valid_r;
  logic [rc4_pkg::BYTE_W-1:0]  rd_data_r;
  logic [rc4_pkg::PERM_AW-1:0] rd_addr_r;
  logic                        rd_valid_r;

  // Read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      perm_mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rd_data_r  <= perm_mem[cmd.raddr];
      rd_addr_r  <= cmd.raddr;
      rd_valid_r <= valid_r[cmd.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.we) begin
      valid_r[cmd.waddr] <= 1'b1;
    end
  end

  // Identity value: the entry's own index
  assign rdata = rd_valid_r ? rd_data_r : rc4_pkg::BYTE_W'(rd_addr_r);

endmodule
